// ===== hw/rtl/lie_pkg.sv =====
// Package for the indexed list engine: command, status and state codes.
// Has no dependencies; used by lie_mem and indexed_list_engine.
`default_nettype none
package lie_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_INSERT_AT  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_REAR   = 3'd4,
        CMD_REMOVE_AT  = 3'd5,
        CMD_FIND       = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_FIND,
        S_DONE
    } t_state;

    localparam int VAL_W = 32;
    localparam int IDX_W = 7;

endpackage
`default_nettype wire

// ===== hw/rtl/lie_mem.sv =====
// Entry storage for the indexed list engine: one write port, one read port.
// Read data is registered. Uses lie_pkg for the data width.
`default_nettype none
module lie_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [lie_pkg::VAL_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [lie_pkg::VAL_W-1:0]  o_rdata
);

    logic [lie_pkg::VAL_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_engine.sv =====
// Indexed list engine: an ordered list of up to DEPTH signed 32-bit values
// kept in one synchronous RAM. Pushes and inserts that append at the end,
// and commands that only return a status, offer their result in the cycle
// after acceptance. Inserts and removes that move entries take longer the
// more entries lie at or above the index, and a find the later its match
// comes (it compares the whole list when the value is absent), because
// every entry that moves or is compared passes once through the RAM's
// single read port. One item is handled at a time; the block returns to
// idle in the cycle after the result is taken, so it never accepts a new
// item in the cycle in which a result is taken. Depends on lie_pkg and lie_mem.
`default_nettype none
module indexed_list_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [2:0]                        i_command,
    input  wire logic [lie_pkg::IDX_W-1:0]         i_position,
    input  wire logic signed [lie_pkg::VAL_W-1:0]  i_item_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [lie_pkg::VAL_W-1:0]       o_result_value,
    output logic signed [lie_pkg::IDX_W-1:0]       o_found_index,
    output logic [2:0]                             o_status,
    output logic [lie_pkg::IDX_W-1:0]              o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > lie_pkg::IDX_W) ? CW : lie_pkg::IDX_W;

    lie_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_dptr, n_dptr;
    logic [AW-1:0]   r_stop, n_stop;
    logic [AW-1:0]   r_first, n_first;
    logic            r_issue, n_issue;
    logic            r_dv, n_dv;
    logic [lie_pkg::VAL_W-1:0] r_val, n_val;
    logic [lie_pkg::VAL_W-1:0] r_rv, n_rv;
    logic [lie_pkg::IDX_W-1:0] r_fidx, n_fidx;
    logic [2:0]      r_st, n_st;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [lie_pkg::VAL_W-1:0] mem_wdata;
    logic [lie_pkg::VAL_W-1:0] mem_rdata;

    logic [XW-1:0] pos_x, cnt_x, ins_pos, rem_pos;
    logic [CW-1:0] cnt_m1;

    lie_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    assign pos_x  = XW'(i_position);
    assign cnt_x  = XW'(r_count);
    assign cnt_m1 = r_count - CW'(1);

    // Effective index for the insert and remove families.
    always_comb begin
        case (i_command)
            lie_pkg::CMD_PUSH_FRONT: ins_pos = '0;
            lie_pkg::CMD_PUSH_REAR:  ins_pos = cnt_x;
            default:                 ins_pos = pos_x;
        endcase
        case (i_command)
            lie_pkg::CMD_POP_FRONT: rem_pos = '0;
            lie_pkg::CMD_POP_REAR:  rem_pos = XW'(cnt_m1);
            default:                rem_pos = pos_x;
        endcase
    end

    assign o_ready        = (r_state == lie_pkg::S_IDLE);
    assign o_valid        = (r_state == lie_pkg::S_DONE);
    assign o_result_value = r_rv;
    assign o_found_index  = r_fidx;
    assign o_status       = r_st;
    assign o_entry_count  = lie_pkg::IDX_W'(r_count);

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lie_pkg::S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_dv    <= n_dv;
        end
        r_ptr   <= n_ptr;
        r_dptr  <= n_dptr;
        r_stop  <= n_stop;
        r_first <= n_first;
        r_val   <= n_val;
        r_rv    <= n_rv;
        r_fidx  <= n_fidx;
        r_st    <= n_st;
    end

    // Next state: decode the item, then stream entries through the RAM.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_dptr    = r_ptr;
        n_stop    = r_stop;
        n_first   = r_first;
        n_issue   = r_issue;
        n_dv      = 1'b0;
        n_val     = r_val;
        n_rv      = r_rv;
        n_fidx    = r_fidx;
        n_st      = r_st;
        mem_we    = 1'b0;
        mem_waddr = r_dptr;
        mem_wdata = mem_rdata;

        case (r_state)
            lie_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_val   = i_item_value;
                    n_rv    = '0;
                    n_fidx  = '0;
                    n_st    = lie_pkg::ST_OK;
                    n_state = lie_pkg::S_DONE;
                    case (i_command)
                        lie_pkg::CMD_PUSH_FRONT, lie_pkg::CMD_PUSH_REAR,
                        lie_pkg::CMD_INSERT_AT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_st = lie_pkg::ST_FULL;
                            end else if (ins_pos > cnt_x) begin
                                n_st = lie_pkg::ST_BADPOS;
                            end else if (ins_pos == cnt_x) begin
                                // Append: no entries move.
                                mem_we    = 1'b1;
                                mem_waddr = ins_pos[AW-1:0];
                                mem_wdata = i_item_value;
                                n_count   = r_count + CW'(1);
                            end else begin
                                n_ptr   = cnt_m1[AW-1:0];
                                n_stop  = ins_pos[AW-1:0];
                                n_issue = 1'b1;
                                n_state = lie_pkg::S_SHIFT_UP;
                            end
                        end
                        lie_pkg::CMD_POP_FRONT, lie_pkg::CMD_POP_REAR,
                        lie_pkg::CMD_REMOVE_AT: begin
                            if (r_count == '0) begin
                                n_st = lie_pkg::ST_EMPTY;
                            end else if (rem_pos >= cnt_x) begin
                                n_st = lie_pkg::ST_BADPOS;
                            end else begin
                                n_ptr   = rem_pos[AW-1:0];
                                n_first = rem_pos[AW-1:0];
                                n_stop  = cnt_m1[AW-1:0];
                                n_issue = 1'b1;
                                n_state = lie_pkg::S_SHIFT_DN;
                            end
                        end
                        lie_pkg::CMD_FIND: begin
                            if (r_count == '0) begin
                                n_st   = lie_pkg::ST_NOTFOUND;
                                n_fidx = '1;
                            end else begin
                                n_ptr   = '0;
                                n_stop  = cnt_m1[AW-1:0];
                                n_issue = 1'b1;
                                n_state = lie_pkg::S_FIND;
                            end
                        end
                        default: begin
                            n_st = lie_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end

            // Read from the top down and write each entry one place higher.
            lie_pkg::S_SHIFT_UP: begin
                n_dv = r_issue;
                if (r_issue) begin
                    if (r_ptr == r_stop) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr - AW'(1);
                    end
                end
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_dptr + AW'(1);
                    if (r_dptr == r_stop) begin
                        n_state = lie_pkg::S_INS_WR;
                    end
                end
            end

            // Drop the new item into the opened slot.
            lie_pkg::S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_stop;
                mem_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_state   = lie_pkg::S_DONE;
            end

            // Read upward; the first entry is the removed value, the rest
            // move one place lower.
            lie_pkg::S_SHIFT_DN: begin
                n_dv = r_issue;
                if (r_issue) begin
                    if (r_ptr == r_stop) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
                if (r_dv) begin
                    if (r_dptr == r_first) begin
                        n_rv = mem_rdata;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_dptr - AW'(1);
                    end
                    if (r_dptr == r_stop) begin
                        n_count = cnt_m1;
                        n_state = lie_pkg::S_DONE;
                    end
                end
            end

            // Compare each entry in order and stop at the first match.
            lie_pkg::S_FIND: begin
                n_dv = r_issue;
                if (r_issue) begin
                    if (r_ptr == r_stop) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
                if (r_dv) begin
                    if (mem_rdata == r_val) begin
                        n_fidx  = lie_pkg::IDX_W'(r_dptr);
                        n_issue = 1'b0;
                        n_dv    = 1'b0;
                        n_state = lie_pkg::S_DONE;
                    end else if (r_dptr == r_stop) begin
                        n_fidx  = '1;
                        n_st    = lie_pkg::ST_NOTFOUND;
                        n_state = lie_pkg::S_DONE;
                    end
                end
            end

            // Hold the result until it is taken.
            lie_pkg::S_DONE: begin
                if (i_ready) begin
                    n_state = lie_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lie_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sim/tb_indexed_list_engine.sv =====
// Testbench for the indexed list engine: random and directed list commands
// checked against a behavioral list held in a scoreboard class.
// Depends on lie_pkg and the indexed_list_engine RTL.
`default_nettype none
module tb_indexed_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [6:0]  index;
        logic [2:0]         status;
        logic [6:0]         count;
    } t_list_result;

    // Shadow list and queue of expected results.
    class list_scoreboard;
        logic signed [31:0] shadow[$];
        t_list_result pending[$];
        int mismatches;
        int checked;

        function void note_command(logic [2:0] cmd, logic [6:0] pos,
                                   logic signed [31:0] val);
            t_list_result r;
            int p;
            r = '0;
            r.status = lie_pkg::ST_OK;
            case (cmd)
                lie_pkg::CMD_PUSH_FRONT, lie_pkg::CMD_PUSH_REAR,
                lie_pkg::CMD_INSERT_AT: begin
                    p = (cmd == lie_pkg::CMD_PUSH_FRONT) ? 0 :
                        (cmd == lie_pkg::CMD_PUSH_REAR) ? shadow.size() : int'(pos);
                    if (shadow.size() >= DEPTH) r.status = lie_pkg::ST_FULL;
                    else if (p > shadow.size()) r.status = lie_pkg::ST_BADPOS;
                    else shadow.insert(p, val);
                end
                lie_pkg::CMD_POP_FRONT, lie_pkg::CMD_POP_REAR,
                lie_pkg::CMD_REMOVE_AT: begin
                    p = (cmd == lie_pkg::CMD_POP_FRONT) ? 0 :
                        (cmd == lie_pkg::CMD_POP_REAR) ? shadow.size() - 1 : int'(pos);
                    if (shadow.size() == 0) r.status = lie_pkg::ST_EMPTY;
                    else if (p >= shadow.size()) r.status = lie_pkg::ST_BADPOS;
                    else begin
                        r.value = shadow[p];
                        shadow.delete(p);
                    end
                end
                lie_pkg::CMD_FIND: begin
                    r.status = lie_pkg::ST_NOTFOUND;
                    r.index = '1;
                    for (int i = 0; i < shadow.size(); i++) begin
                        if (shadow[i] == val) begin
                            r.status = lie_pkg::ST_OK;
                            r.index = i[6:0];
                            break;
                        end
                    end
                end
                default: r.status = lie_pkg::ST_BADPOS;
            endcase
            r.count = 7'(shadow.size());
            pending.push_back(r);
        endfunction

        function void check_result(t_list_result got);
            t_list_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0;
    logic [2:0] i_command = '0;
    logic [6:0] i_position = '0;
    logic signed [31:0] i_item_value = '0;
    logic o_ready, o_valid;
    logic signed [31:0] o_result_value;
    logic signed [6:0] o_found_index;
    logic [2:0] o_status;
    logic [6:0] o_entry_count;

    indexed_list_engine #(.DEPTH(DEPTH)) dut (.*);

    list_scoreboard board = new();
    int send_idle_pct, recv_stall_pct, items_sent;
    int idle_cycles = 0;
    logic signed [31:0] recent_vals[8];

    initial forever #1 i_clk = ~i_clk;

    // Result side: random stalls, check each accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result({o_result_value, o_found_index, o_status, o_entry_count});
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("indexed_list_engine verification failed");
            $finish;
        end
    end

    // Valid stays high between items unless the sender idles or drains.
    task automatic send_command(logic [2:0] cmd, logic [6:0] pos, logic signed [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= cmd;
        i_position <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (!o_ready);
        board.note_command(cmd, pos, val);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return recent_vals[$urandom_range(7)];
            default: return $urandom;
        endcase
    endfunction

    // One random command, biased so the list fills and empties.
    task automatic random_command(int bias_fill);
        logic [2:0] cmd;
        logic [6:0] pos;
        logic signed [31:0] val;
        int n;
        n = board.shadow.size();
        if ($urandom_range(99) < bias_fill) cmd = 3'($urandom_range(2));
        else cmd = 3'($urandom_range(7));
        if ($urandom_range(9) == 0) pos = 7'($urandom);
        else pos = 7'($urandom_range(n + 1));
        val = pick_value();
        if (cmd <= lie_pkg::CMD_INSERT_AT) recent_vals[$urandom_range(7)] = val;
        send_command(cmd, pos, val);
    endtask

    initial begin
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (recent_vals[i]) recent_vals[i] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty-list cases, extremes, index 0, full list.
        send_command(lie_pkg::CMD_POP_FRONT, 0, 0);
        send_command(lie_pkg::CMD_POP_REAR, 0, 0);
        send_command(lie_pkg::CMD_REMOVE_AT, 0, 0);
        send_command(lie_pkg::CMD_FIND, 0, 5);
        send_command(lie_pkg::CMD_INSERT_AT, 1, 9);
        send_command(lie_pkg::CMD_INSERT_AT, 0, 32'sh7fffffff);
        send_command(lie_pkg::CMD_PUSH_FRONT, 0, 32'sh80000000);
        send_command(lie_pkg::CMD_PUSH_REAR, 7'h7f, -1);
        send_command(lie_pkg::CMD_INSERT_AT, 3, 42);
        send_command(lie_pkg::CMD_INSERT_AT, 1, 42);
        send_command(lie_pkg::CMD_FIND, 0, 42);
        send_command(lie_pkg::CMD_FIND, 0, -1);
        send_command(lie_pkg::CMD_REMOVE_AT, 5, 0);
        send_command(lie_pkg::CMD_REMOVE_AT, 0, 0);
        send_command(3'd7, 7'h55, 32'h5555aaaa);
        send_command(lie_pkg::CMD_POP_REAR, 0, 0);
        while (board.shadow.size() < DEPTH)
            send_command(lie_pkg::CMD_PUSH_REAR, 0, $urandom);
        send_command(lie_pkg::CMD_PUSH_FRONT, 0, 1);
        send_command(lie_pkg::CMD_INSERT_AT, 64, 2);
        send_command(lie_pkg::CMD_REMOVE_AT, 63, 0);
        send_command(lie_pkg::CMD_INSERT_AT, 63, 3);
        send_command(lie_pkg::CMD_FIND, 0, 3);
        wait_drained();

        // Random phases with varied idling and list occupancy.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int k = 0; k < 200; k++) random_command(ph < 4 ? 55 : 25);
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (items_sent < 1700) random_command(40);

        wait_drained();
        $display("Covered %0d list commands over idle and stall phases, %0d results checked.",
                 items_sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("indexed_list_engine verification clean");
        end else begin
            $display("indexed_list_engine verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
